[sv/recaman_sequence_generator_top_defines.svh]
// assertion macros shared by the checker
`ifndef RECAMAN_SEQUENCE_GENERATOR_TOP_DEFINES_SVH
`define RECAMAN_SEQUENCE_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define RECSEQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define RECSEQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/recseq_pkg.sv]
`default_nettype none
package recseq_pkg;

	localparam int MAX_BOUND_DEFAULT = 65536;
	localparam int MAP_DEPTH_LIMIT   = 65536;
	localparam int BOUND_W           = 17;
	localparam int VAL_W             = 16;

	typedef struct packed {
		logic [VAL_W-1:0] term_index;
		logic [VAL_W-1:0] term_value;
		logic             went_backward;
		logic             overflow;
	} result_t;

	typedef struct packed {
		logic active;
		logic wbit;
	} clr_t;

	// round up to a multiple of eight, then limit to the map size
	function automatic logic [BOUND_W-1:0] eff_bound(input logic [BOUND_W-1:0] b,
			input logic [BOUND_W-1:0] cap);
		logic [BOUND_W:0]   r;
		logic [BOUND_W-3:0] rows;
		rows = {1'b0, b[BOUND_W-1:3]} + (BOUND_W-2)'(1);
		if ((b & 17'b111) != '0)
			r = {rows, 3'b000};
		else
			r = {1'b0, b};
		if (r > {1'b0, cap})
			r = {1'b0, cap};
		return r[BOUND_W-1:0];
	endfunction

endpackage
`default_nettype wire

[sv/recseq_ram.sv]
`default_nettype none
module recseq_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[sv/recseq_clear.sv]
`default_nettype none
module recseq_clear #(
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	output recseq_pkg::clr_t              ctl,
	output logic      [$clog2(DEPTH)-1:0] addr
);
	import recseq_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [AW-1:0] addr_q;
	logic          active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q   <= '0;
			active_q <= 1'b1;
		end else if (active_q) begin
			if (addr_q == AW'(DEPTH - 1))
				active_q <= 1'b0;
			else
				addr_q <= addr_q + AW'(1);
		end
	end

	// entry zero starts marked
	assign ctl.active = active_q;
	assign ctl.wbit   = (addr_q == '0);
	assign addr       = addr_q;

endmodule
`default_nettype wire

[sv/recseq_outbuf.sv]
`default_nettype none
module recseq_outbuf (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire recseq_pkg::result_t push_data,
	input  wire logic                pop,
	output logic                     valid,
	output recseq_pkg::result_t      data,
	output logic                     full
);
	import recseq_pkg::*;

	result_t head_q;
	result_t skid_q;
	logic    head_valid_q;
	logic    skid_valid_q;
	logic    head_pop;
	logic    to_head;

	assign head_pop = head_valid_q & pop;
	assign to_head  = push & !skid_valid_q & (!head_valid_q | head_pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (head_pop)
					skid_valid_q <= push;
			end else begin
				if (push && !to_head)
					skid_valid_q <= 1'b1;
				if (to_head)
					head_valid_q <= 1'b1;
				else if (head_pop)
					head_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q && head_pop) begin
			head_q <= skid_q;
			if (push)
				skid_q <= push_data;
		end else if (to_head) begin
			head_q <= push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign valid = head_valid_q;
	assign data  = head_q;
	assign full  = skid_valid_q;

endmodule
`default_nettype wire

[sv/recaman_sequence_generator_top.sv]
// recaman sequence generator: each accepted request returns one term of the
// sequence a(0)=0, a(n)=a(n-1)-n if that is non-negative and not yet seen,
// else a(n-1)+n. the first request after reset reports a(0) whatever advance
// holds; advance=0 repeats the current term, advance=1 steps. a term that
// would reach the bound (cfg value rounded up to a multiple of eight, limited
// to the map depth) sets the sticky overflow flag and freezes the sequence.
// the seen-values bitmap is a one-bit-wide synchronous ram of
// min(MAX_BOUND, 65536) entries. after reset a clearing sweep writes one
// entry per cycle, and requests are held off until it has finished. the
// backward candidate's bitmap entry is read in the request cycle and the
// decision and mark write happen in the following one. a two-entry output
// buffer lets the next request in while a finished result is still waiting
// to be taken. cfg_wdata may only be written while no request is in flight.
`default_nettype none
module recaman_sequence_generator_top #(
	parameter int MAX_BOUND = recseq_pkg::MAX_BOUND_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [recseq_pkg::BOUND_W-1:0]  cfg_wdata,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            advance,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [recseq_pkg::VAL_W-1:0]    term_index,
	output logic      [recseq_pkg::VAL_W-1:0]    term_value,
	output logic                                 went_backward,
	output logic                                 overflow
);
	import recseq_pkg::*;

	localparam int MAP_DEPTH = (MAX_BOUND < MAP_DEPTH_LIMIT) ? MAX_BOUND : MAP_DEPTH_LIMIT;
	localparam int AW        = $clog2(MAP_DEPTH);
	localparam logic [BOUND_W-1:0] BOUND_CAP = BOUND_W'(MAP_DEPTH);

	// sequence state
	logic [VAL_W-1:0]   step_q;
	logic [VAL_W-1:0]   last_q;
	logic               stopped_q;
	logic               started_q;
	logic [BOUND_W-1:0] bound_q;     // effective bound, worked out at write time
	logic               busy_q;      // a request sits in the decision stage

	// request-cycle arithmetic
	logic [BOUND_W-1:0] n;
	logic [BOUND_W-1:0] a17;
	logic [BOUND_W-1:0] back;
	logic               a_ge_n;
	logic               in_acc;

	// decision stage payload
	logic               adv_s1;
	logic               first_s1;
	logic [BOUND_W-1:0] n_s1;
	logic [BOUND_W-1:0] back_s1;
	logic [BOUND_W-1:0] fwd_s1;
	logic               a_ge_n_s1;
	logic               back_in_s1;

	// decision logic
	logic               rd_bit;
	logic               take_back;
	logic [BOUND_W-1:0] next;
	logic               ovf;
	logic               step_en;
	logic               upd;
	result_t            res;

	clr_t               clr;
	logic [AW-1:0]      clr_addr;
	logic               buf_full;
	result_t            out_data;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic               ram_wdata;

	// a new request waits for the decision stage to retire, the sweep to end
	// and a free slot in the output buffer
	assign in_ready = !busy_q && !clr.active && !buf_full;
	assign in_acc   = in_valid & in_ready;

	assign n      = {1'b0, step_q} + BOUND_W'(1);
	assign a17    = {1'b0, last_q};
	assign a_ge_n = (a17 >= n);
	assign back   = a17 - n;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			adv_s1     <= advance;
			first_s1   <= !started_q;
			n_s1       <= n;
			back_s1    <= back;
			fwd_s1     <= a17 + n;
			a_ge_n_s1  <= a_ge_n;
			// a candidate at or past the bound counts as not seen
			back_in_s1 <= a_ge_n && (back < bound_q);
		end
	end

	// backward candidate's bit is valid in the cycle after the request
	assign take_back = a_ge_n_s1 && !(back_in_s1 && rd_bit);
	assign next      = take_back ? back_s1 : fwd_s1;
	assign ovf       = (next >= bound_q) || n_s1[BOUND_W-1];
	assign step_en   = busy_q && !first_s1 && adv_s1 && !stopped_q;
	assign upd       = step_en && !ovf;

	assign res.term_index    = upd ? n_s1[VAL_W-1:0] : step_q;
	assign res.term_value    = upd ? next[VAL_W-1:0] : last_q;
	assign res.went_backward = upd && take_back;
	assign res.overflow      = stopped_q || (step_en && ovf);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= '0;
			last_q    <= '0;
			stopped_q <= 1'b0;
			started_q <= 1'b0;
			busy_q    <= 1'b0;
			bound_q   <= eff_bound(BOUND_W'(65536), BOUND_CAP);
		end else begin
			if (cfg_we)
				bound_q <= eff_bound(cfg_wdata, BOUND_CAP);
			if (in_acc)
				started_q <= 1'b1;
			busy_q <= in_acc;
			if (upd) begin
				step_q <= n_s1[VAL_W-1:0];
				last_q <= next[VAL_W-1:0];
			end
			if (step_en && ovf)
				stopped_q <= 1'b1;
		end
	end

	// the mark is written on the retire edge; no read is issued while a request
	// retires, so a read never races a write to the same entry
	assign ram_we    = clr.active | upd;
	assign ram_waddr = clr.active ? clr_addr : next[AW-1:0];
	assign ram_wdata = clr.active ? clr.wbit : 1'b1;

	recseq_clear #(
		.DEPTH (MAP_DEPTH)
	) u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (clr),
		.addr   (clr_addr)
	);

	recseq_ram #(
		.WIDTH (1),
		.DEPTH (MAP_DEPTH)
	) u_seen_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (in_acc),
		.raddr (back[AW-1:0]),
		.rdata (rd_bit)
	);

	recseq_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (busy_q),
		.push_data (res),
		.pop       (out_ready),
		.valid     (out_valid),
		.data      (out_data),
		.full      (buf_full)
	);

	assign term_index    = out_data.term_index;
	assign term_value    = out_data.term_value;
	assign went_backward = out_data.went_backward;
	assign overflow      = out_data.overflow;

endmodule
`default_nettype wire

[sv/recseq_checker.sv]
`default_nettype none
`include "recaman_sequence_generator_top_defines.svh"
module recseq_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	input  wire logic                            in_ready,
	input  wire logic                            out_valid,
	input  wire logic                            out_ready,
	input  wire logic [recseq_pkg::VAL_W-1:0]    term_index,
	input  wire logic [recseq_pkg::VAL_W-1:0]    term_value,
	input  wire logic                            went_backward,
	input  wire logic                            overflow
);

	logic                              out_stall;
	logic [2*recseq_pkg::VAL_W+1:0]    out_word;

	assign out_stall = out_valid && !out_ready;
	assign out_word  = {term_index, term_value, went_backward, overflow};

	// in_ready is low while an accepted request is in the decision stage
	`RECSEQ_ASSERT_NEXT(a_req_spacing, in_valid && in_ready, !in_ready, "request too soon")

	// an overflowed result never reports a backward step
	`RECSEQ_ASSERT_NOW(a_ovf_no_back, out_valid && overflow, !went_backward, "ovf with back")

	// a backward step is never the zeroth term
	`RECSEQ_ASSERT_NOW(a_back_index, out_valid && went_backward, term_index != '0, "back at zero")

	// a stalled result holds
	`RECSEQ_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "stall changed")

endmodule
bind recaman_sequence_generator_top recseq_checker u_recseq_checker (.*);
`default_nettype wire
